// ===== design/tcfb_pkg.sv =====
package tcfb_pkg;

  // default length of a held run before it is written out raw
  localparam int HOLD_LIMIT_DEF = 32;

  // telnet codes
  localparam logic [7:0] T_IAC     = 8'd255;
  localparam logic [7:0] T_WILL    = 8'd251;
  localparam logic [7:0] T_WONT    = 8'd252;
  localparam logic [7:0] T_SB      = 8'd250;
  localparam logic [7:0] T_SE      = 8'd240;
  localparam logic [7:0] T_NOP     = 8'd241;
  localparam logic [7:0] T_AYT     = 8'd246;
  localparam logic [7:0] T_IP      = 8'd244;
  localparam logic [7:0] T_COMPORT = 8'd44;
  localparam logic [7:0] T_SETBAUD = 8'd1;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_BAUD  = 2'd1,
    KIND_AYT   = 2'd2,
    KIND_CLOSE = 2'd3
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FL_RD,
    S_FL_EM,
    S_DEC_RD,
    S_DEC_ACC,
    S_ONE
  } state_t;

  // one result beat from the sequencer to the output register
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    logic [31:0] baud_value;
    logic        last;
  } result_t;

endpackage

// ===== design/tcfb_hold_mem.sv =====
module tcfb_hold_mem #(
  parameter int DEPTH = tcfb_pkg::HOLD_LIMIT_DEF + 1,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tcfb_baud_acc.sv =====
module tcfb_baud_acc (
  input  logic        clk,
  input  logic        clear,
  input  logic        step,
  input  logic [7:0]  din,
  output logic [31:0] baud
);
  import tcfb_pkg::*;

  // skip: the last byte shifted in was an unpaired iac, so a following iac is its escape
  logic skip;

  always_ff @(posedge clk) begin
    if (clear) begin
      baud <= '0;
      skip <= 1'b0;
    end else if (step) begin
      if (skip && din == T_IAC) begin
        skip <= 1'b0;
      end else begin
        baud <= {baud[23:0], din};
        skip <= (din == T_IAC);
      end
    end
  end

endmodule

// ===== design/tcfb_ctrl.sv =====
module tcfb_ctrl #(
  parameter int HOLD_LIMIT = tcfb_pkg::HOLD_LIMIT_DEF,
  parameter int CW         = $clog2(HOLD_LIMIT + 2),
  parameter int AW         = $clog2(HOLD_LIMIT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic [7:0]        rx_byte,
  input  logic              chunk_end,
  output logic              item_stall,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [7:0]        mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [7:0]        mem_rdata,
  output logic              acc_clear,
  output logic              acc_step,
  input  logic [31:0]       acc_baud,
  output logic              emit_valid,
  output tcfb_pkg::result_t emit,
  input  logic              emit_ready
);
  import tcfb_pkg::*;

  localparam logic [CW-1:0] LIMIT = CW'(HOLD_LIMIT);

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;
  logic          discard, discard_next;
  logic          prev_iac, prev_iac_next;
  logic          held3, held3_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] lim, lim_next;
  logic          tail_valid, tail_valid_next;
  logic [7:0]    tail_byte, tail_byte_next;
  kind_t         one_kind, one_kind_next;
  logic [CW-1:0] ncount;

  assign ncount = count + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      discard <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      discard <= discard_next;
    end
  end

  always_ff @(posedge clk) begin
    prev_iac   <= prev_iac_next;
    held3      <= held3_next;
    idx        <= idx_next;
    lim        <= lim_next;
    tail_valid <= tail_valid_next;
    tail_byte  <= tail_byte_next;
    one_kind   <= one_kind_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    discard_next    = discard;
    prev_iac_next   = prev_iac;
    held3_next      = held3;
    idx_next        = idx;
    lim_next        = lim;
    tail_valid_next = tail_valid;
    tail_byte_next  = tail_byte;
    one_kind_next   = one_kind;
    item_stall      = 1'b1;
    mem_we          = 1'b0;
    mem_waddr       = count[AW-1:0];
    mem_wdata       = rx_byte;
    mem_re          = 1'b0;
    mem_raddr       = idx[AW-1:0];
    acc_clear       = 1'b0;
    acc_step        = 1'b0;
    emit_valid      = 1'b0;
    emit.kind       = KIND_DATA;
    emit.out_byte   = '0;
    emit.baud_value = '0;
    emit.last       = 1'b0;

    unique case (state)
      S_IDLE: begin
        item_stall = 1'b0;
        idx_next   = '0;
        if (item_valid) begin
          if (discard) begin
            if (chunk_end) begin
              discard_next = 1'b0;
            end
          end else if (count == '0 && rx_byte == T_IAC) begin
            mem_we        = 1'b1;
            prev_iac_next = 1'b1;
            count_next    = ncount;
          end else if (count == CW'(1)) begin
            case (rx_byte) inside
              T_WILL, T_WONT, T_SB: begin
                mem_we        = 1'b1;
                prev_iac_next = 1'b0;
                count_next    = ncount;
              end
              T_SE, T_NOP: begin
                count_next = '0;
              end
              T_AYT: begin
                count_next     = '0;
                one_kind_next  = KIND_AYT;
                tail_byte_next = '0;
                state_next     = S_ONE;
              end
              T_IP: begin
                count_next     = '0;
                one_kind_next  = KIND_CLOSE;
                tail_byte_next = '0;
                discard_next   = !chunk_end;
                state_next     = S_ONE;
              end
              default: begin
                // held iac goes out first, then this byte
                count_next      = '0;
                lim_next        = count;
                tail_valid_next = 1'b1;
                tail_byte_next  = rx_byte;
                one_kind_next   = KIND_DATA;
                state_next      = S_FL_RD;
              end
            endcase
          end else if (count == CW'(2) && rx_byte == T_COMPORT) begin
            mem_we        = 1'b1;
            prev_iac_next = 1'b0;
            count_next    = ncount;
          end else if (count > CW'(2)) begin
            mem_we        = 1'b1;
            prev_iac_next = (rx_byte == T_IAC);
            if (count == CW'(3)) begin
              held3_next = (rx_byte == T_SETBAUD);
            end
            if (rx_byte == T_SE && prev_iac) begin
              count_next = '0;
              if (ncount >= CW'(6) && held3) begin
                acc_clear  = 1'b1;
                idx_next   = CW'(4);
                lim_next   = ncount - CW'(2);
                state_next = S_DEC_RD;
              end
            end else if (ncount > LIMIT) begin
              count_next      = '0;
              lim_next        = ncount;
              tail_valid_next = 1'b0;
              state_next      = S_FL_RD;
            end else begin
              count_next = ncount;
            end
          end else begin
            count_next      = '0;
            lim_next        = count;
            tail_valid_next = 1'b1;
            tail_byte_next  = rx_byte;
            one_kind_next   = KIND_DATA;
            state_next      = S_FL_RD;
          end
        end
      end

      S_FL_RD: begin
        if (idx != lim) begin
          mem_re     = 1'b1;
          state_next = S_FL_EM;
        end else if (tail_valid) begin
          state_next = S_ONE;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_FL_EM: begin
        emit_valid    = 1'b1;
        emit.out_byte = mem_rdata;
        emit.last     = (idx + CW'(1) == lim) && !tail_valid;
        if (emit_ready) begin
          idx_next   = idx + CW'(1);
          state_next = S_FL_RD;
        end
      end

      S_DEC_RD: begin
        if (idx < lim) begin
          mem_re     = 1'b1;
          state_next = S_DEC_ACC;
        end else if (acc_baud != '0) begin
          one_kind_next  = KIND_BAUD;
          tail_byte_next = '0;
          state_next     = S_ONE;
        end else begin
          state_next = S_IDLE;
        end
      end

      S_DEC_ACC: begin
        acc_step   = 1'b1;
        idx_next   = idx + CW'(1);
        state_next = S_DEC_RD;
      end

      S_ONE: begin
        emit_valid      = 1'b1;
        emit.kind       = one_kind;
        emit.out_byte   = tail_byte;
        emit.baud_value = (one_kind == KIND_BAUD) ? acc_baud : '0;
        emit.last       = 1'b1;
        if (emit_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/telnet_command_filter_baud_unit.sv =====
// a plain byte goes through the S_FL_RD and S_ONE states, then the output register
// input is taken only in S_IDLE: item_stall holds new bytes while a beat is emitted
//   or a held run is walked in the hold memory for write-out or decode; output stalls
//   hold any beat
// reset: rst clears sequencer, held count and discard flag; hold memory is not cleared
// the output register lets the sequencer finish the next beat while one waits
module telnet_command_filter_baud_unit #(
  parameter int HOLD_LIMIT = tcfb_pkg::HOLD_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // incoming network bytes
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  rx_byte,
  input  logic        chunk_end,
  // result beats
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  kind,
  output logic [7:0]  out_byte,
  output logic [31:0] baud_value,
  output logic        last
);
  import tcfb_pkg::*;

  // held count must reach HOLD_LIMIT+1 on overflow; memory holds that many bytes
  localparam int DEPTH = HOLD_LIMIT + 1;
  localparam int CW    = $clog2(HOLD_LIMIT + 2);
  localparam int AW    = $clog2(DEPTH);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          acc_clear;
  logic          acc_step;
  logic [31:0]   acc_baud;
  logic          emit_valid;
  result_t       emit;
  logic          emit_ready;
  result_t       out_reg;

  // sequencer: classifies each byte, then walks the held run for flush or decode
  tcfb_ctrl #(
    .HOLD_LIMIT (HOLD_LIMIT),
    .CW         (CW),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .rx_byte    (rx_byte),
    .chunk_end  (chunk_end),
    .item_stall (item_stall),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .acc_clear  (acc_clear),
    .acc_step   (acc_step),
    .acc_baud   (acc_baud),
    .emit_valid (emit_valid),
    .emit       (emit),
    .emit_ready (emit_ready)
  );

  // held sequence store, one byte per cycle in or out
  tcfb_hold_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // shift unit: big-endian baud build with iac iac unescape
  tcfb_baud_acc u_acc (
    .clk   (clk),
    .clear (acc_clear),
    .step  (acc_step),
    .din   (mem_rdata),
    .baud  (acc_baud)
  );

  // output register: loads when empty or when the waiting beat is taken
  assign emit_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_ready) begin
      result_valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      out_reg <= emit;
    end
  end

  assign kind       = out_reg.kind;
  assign out_byte   = out_reg.out_byte;
  assign baud_value = out_reg.baud_value;
  assign last       = out_reg.last;

endmodule
